// ----- hw/rtl/waveform_tone_generator_assert.svh -----
// Assertion macros used by the tone generator top level.
`ifndef WAVEFORM_TONE_GENERATOR_ASSERT_SVH
`define WAVEFORM_TONE_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WTG_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("tone generator check failed");

// The consequent must hold in the cycle after the antecedent.
`define WTG_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("tone generator check failed");

`endif

// ----- hw/rtl/wtg_pkg.sv -----
// Types, constants and the sine table of the tone generator.
package wtg_pkg;

    localparam int SAMPLE_RATE      = 44100;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_ADDR_W      = SINE_IDX_W + 1;

    localparam int OP_W       = 2;
    localparam int FREQ_W     = 16;
    localparam int VOL_W      = 8;
    localparam int SHAPE_W    = 3;
    localparam int DUR_W      = 16;
    localparam int SAMPLE_W   = 14;
    localparam int PHASE_W    = 32;
    localparam int COUNT_W    = 22;
    localparam int NOISE_W    = 32;
    localparam int WAVE_W     = 18;
    localparam int MAG_W      = 16;
    localparam int ROM_W      = 16;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 3'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 3'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_SAW      = 3'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 3'd3;
    localparam logic [SHAPE_W-1:0] SHAPE_NOISE    = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [NOISE_W-1:0] NOISE_SEED = 32'h0123_4567;
    localparam int NOISE_SHL_A = 13;
    localparam int NOISE_SHR_B = 17;
    localparam int NOISE_SHL_C = 5;

    localparam logic signed [WAVE_W-1:0] WAVE_FULL = 18'sd32768;

    // Phase step: freq * 2^32 / rate = freq * base + (freq * rem) / rate.
    localparam logic [63:0] PHASE_ONE   = 64'd1 << PHASE_W;
    localparam logic [63:0] STEP_BASE   = PHASE_ONE / SAMPLE_RATE;
    localparam logic [63:0] STEP_REM    = PHASE_ONE % SAMPLE_RATE;
    localparam int RATE_W      = $clog2(SAMPLE_RATE + 1);
    localparam int STEP_BASE_W = $clog2(STEP_BASE + 1);
    localparam int STEP_HI_W   = FREQ_W + STEP_BASE_W;
    localparam int STEP_X_W    = FREQ_W + RATE_W;
    localparam logic [63:0] STEP_RCP = (64'd1 << STEP_X_W) / SAMPLE_RATE;
    localparam int STEP_RCP_W  = $clog2(STEP_RCP + 1);
    localparam int STEP_PX_W   = STEP_X_W + STEP_RCP_W;

    // Sample count: dur * rate / 1000 = dur * base + (dur * rem) / 1000.
    localparam int MS_PER_S    = 1000;
    localparam int MS_W        = $clog2(MS_PER_S + 1);
    localparam int CNT_BASE    = SAMPLE_RATE / MS_PER_S;
    localparam int CNT_REM     = SAMPLE_RATE % MS_PER_S;
    localparam int CNT_BASE_W  = $clog2(CNT_BASE + 1);
    localparam int CNT_FULL_W  = DUR_W + CNT_BASE_W + 1;
    localparam int CNT_Y_W     = DUR_W + MS_W;
    localparam logic [63:0] CNT_RCP = (64'd1 << CNT_Y_W) / MS_PER_S;
    localparam int CNT_RCP_W   = $clog2(CNT_RCP + 1);
    localparam int CNT_PY_W    = CNT_Y_W + CNT_RCP_W;

    // Gain: (|w| * vol + 510) / 1020 as one exact reciprocal multiply.
    localparam int GAIN_DIV     = 1020;
    localparam int SCALE_SHIFT  = 34;
    localparam logic [63:0] SCALE_RCP =
        ((64'd1 << SCALE_SHIFT) + GAIN_DIV - 1) / GAIN_DIV;
    localparam int SCALE_RCP_W  = $clog2(SCALE_RCP + 1);
    localparam int GMUL_W       = VOL_W + SCALE_RCP_W;
    localparam int SCALE_PROD_W = MAG_W + GMUL_W;
    localparam int SCALE_Q_W    = SCALE_PROD_W - SCALE_SHIFT;
    localparam logic [63:0] SCALE_BIAS = (GAIN_DIV / 2) * SCALE_RCP;
    localparam int SAMPLE_POS_LIM = 8191;
    localparam int SAMPLE_NEG_LIM = 8192;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 14'sd8191;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -14'sd8192;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210, 64'd272};

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FREQ_W-1:0]  frequency;
        logic [VOL_W-1:0]   volume;
        logic [SHAPE_W-1:0] waveform;
        logic [DUR_W-1:0]   duration_ms;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       tone_finished;
        logic                       tone_active;
    } t_out_beat;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SHAPE_W-1:0] shape;
        logic [GMUL_W-1:0]  gmul;
        logic [PHASE_W-1:0] step;
        logic [COUNT_W-1:0] count;
        logic               endless;
    } t_cmd;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

    typedef logic [ROM_W-1:0] t_sine_rom [0:SINE_TABLE_DEPTH];

    // Quarter-wave table: Q30 Taylor series, rounded half up to Q15.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom          rom;
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
            term = x;
            sum  = signed'(x);
            for (int k = 1; k <= 8; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / TAYLOR_DIV[k];
                if (k % 2 == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            rom[i] = ROM_W'((64'(sum) + 64'd16384) >> 15);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

// ----- hw/rtl/waveform_tone_generator.sv -----
// Top level of the phase-accumulator tone generator.
// Usage:
// One input beat carries an op (tick, start, stop) with the tone settings.
// Every accepted input beat yields exactly one output beat, in order.
// A start beat loads step, gain, waveform and sample count; a stop beat silences
// the tone; a tick returns one scaled sample and, if playing, advances the phase.
// The output beat's valid rises after its input beat has passed through
// three front-end stages, the command queue, and three engine stages.
// Throughput is one beat per cycle in steady state while the receiver holds ready
// high, set by the phase, count and noise update in the engine.
// The sine wave comes from a constant quarter-wave table; there is no fill time.
// When the receiver holds ready low, the engine and its output register hold,
// the 8-entry command queue fills, and input ready drops once 8 beats are in
// flight ahead of the engine. Nothing is dropped.
// Reset (synchronous, active low) silences the tone, clears phase and count,
// reseeds the noise generator and empties the queue and all pipeline stages.
`include "waveform_tone_generator_assert.svh"

module waveform_tone_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  wtg_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output wtg_pkg::t_out_beat o_out_beat
);
    import wtg_pkg::*;

    logic      w_push;
    logic      w_pop;
    t_cmd      w_push_cmd;
    t_cmd      w_head_cmd;
    t_q_status w_q_status;

    wtg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_beat  (i_in_beat),
        .o_in_ready (o_in_ready),
        .i_pop      (w_pop),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    wtg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_q_status)
    );

    wtg_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_head_cmd),
        .i_status    (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    `WTG_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, w_push, !w_q_status.full)
    `WTG_ASSERT_NOW(a_pop_has_data, i_clk, i_rst_n, w_pop, w_q_status.not_empty)
    `WTG_ASSERT_NOW(a_finish_ends_tone, i_clk, i_rst_n,
        o_out_valid && o_out_beat.tone_finished, !o_out_beat.tone_active)
    `WTG_ASSERT_NEXT(a_ready_waits_for_pop, i_clk, i_rst_n,
        !o_in_ready && !w_pop, !o_in_ready)

endmodule

// ----- hw/rtl/wtg_front.sv -----
// Front end: accepts input beats and works out phase step, count and gain.
module wtg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  wtg_pkg::t_in_beat i_in_beat,
    output logic              o_in_ready,
    input  logic              i_pop,
    output logic              o_push,
    output wtg_pkg::t_cmd     o_cmd
);
    import wtg_pkg::*;

    logic                   w_accept;
    logic [QUEUE_CNT_W-1:0] r_used;
    logic [QUEUE_CNT_W-1:0] n_used;

    logic                   r_s1_valid;
    logic [OP_W-1:0]        r_s1_op;
    logic [SHAPE_W-1:0]     r_s1_shape;
    logic [STEP_HI_W-1:0]   r_s1_base;
    logic [STEP_X_W-1:0]    r_s1_x;
    logic [CNT_FULL_W-1:0]  r_s1_cb;
    logic [CNT_Y_W-1:0]     r_s1_y;
    logic [GMUL_W-1:0]      r_s1_gmul;

    logic                   r_s2_valid;
    logic [OP_W-1:0]        r_s2_op;
    logic [SHAPE_W-1:0]     r_s2_shape;
    logic [STEP_HI_W-1:0]   r_s2_base;
    logic [STEP_X_W-1:0]    r_s2_x;
    logic [STEP_PX_W-1:0]   r_s2_px;
    logic [CNT_FULL_W-1:0]  r_s2_cb;
    logic [CNT_Y_W-1:0]     r_s2_y;
    logic [CNT_PY_W-1:0]    r_s2_py;
    logic [GMUL_W-1:0]      r_s2_gmul;

    logic                   r_s3_valid;
    logic [OP_W-1:0]        r_s3_op;
    logic [SHAPE_W-1:0]     r_s3_shape;
    logic [STEP_HI_W-1:0]   r_s3_base;
    logic [STEP_X_W-1:0]    r_s3_x;
    logic [STEP_RCP_W-1:0]  r_s3_qx;
    logic [STEP_X_W-1:0]    r_s3_qdx;
    logic [CNT_FULL_W-1:0]  r_s3_cb;
    logic [CNT_Y_W-1:0]     r_s3_y;
    logic [CNT_RCP_W-1:0]   r_s3_qy;
    logic [CNT_Y_W-1:0]     r_s3_qdy;
    logic [GMUL_W-1:0]      r_s3_gmul;

    logic [STEP_RCP_W-1:0]  w_qx;
    logic [CNT_RCP_W-1:0]   w_qy;
    logic [STEP_X_W-1:0]    w_rem_x;
    logic [CNT_Y_W-1:0]     w_rem_y;
    logic                   w_fix_x;
    logic                   w_fix_y;
    logic [CNT_FULL_W-1:0]  w_count;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_used < QUEUE_CNT_W'(QUEUE_DEPTH));

    always_comb begin
        n_used = r_used;
        if (w_accept && !i_pop) begin
            n_used = r_used + 1'b1;
        end else if (!w_accept && i_pop) begin
            n_used = r_used - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_used     <= n_used;
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    assign w_qx = r_s2_px[STEP_X_W +: STEP_RCP_W];
    assign w_qy = r_s2_py[CNT_Y_W +: CNT_RCP_W];

    always_ff @(posedge i_clk) begin
        r_s1_op    <= i_in_beat.op;
        r_s1_shape <= i_in_beat.waveform;
        r_s1_base  <= STEP_HI_W'(i_in_beat.frequency) * STEP_HI_W'(STEP_BASE);
        r_s1_x     <= STEP_X_W'(i_in_beat.frequency) * STEP_X_W'(STEP_REM);
        r_s1_cb    <= CNT_FULL_W'(i_in_beat.duration_ms) * CNT_FULL_W'(CNT_BASE);
        r_s1_y     <= CNT_Y_W'(i_in_beat.duration_ms) * CNT_Y_W'(CNT_REM);
        r_s1_gmul  <= GMUL_W'(i_in_beat.volume) * GMUL_W'(SCALE_RCP);

        r_s2_op    <= r_s1_op;
        r_s2_shape <= r_s1_shape;
        r_s2_base  <= r_s1_base;
        r_s2_x     <= r_s1_x;
        r_s2_px    <= STEP_PX_W'(r_s1_x) * STEP_PX_W'(STEP_RCP);
        r_s2_cb    <= r_s1_cb;
        r_s2_y     <= r_s1_y;
        r_s2_py    <= CNT_PY_W'(r_s1_y) * CNT_PY_W'(CNT_RCP);
        r_s2_gmul  <= r_s1_gmul;

        r_s3_op    <= r_s2_op;
        r_s3_shape <= r_s2_shape;
        r_s3_base  <= r_s2_base;
        r_s3_x     <= r_s2_x;
        r_s3_qx    <= w_qx;
        r_s3_qdx   <= STEP_X_W'(w_qx) * STEP_X_W'(SAMPLE_RATE);
        r_s3_cb    <= r_s2_cb;
        r_s3_y     <= r_s2_y;
        r_s3_qy    <= w_qy;
        r_s3_qdy   <= CNT_Y_W'(w_qy) * CNT_Y_W'(MS_PER_S);
        r_s3_gmul  <= r_s2_gmul;
    end

    // The reciprocal estimate is at most one below the true quotient.
    assign w_rem_x = r_s3_x - r_s3_qdx;
    assign w_rem_y = r_s3_y - r_s3_qdy;
    assign w_fix_x = (w_rem_x >= STEP_X_W'(SAMPLE_RATE));
    assign w_fix_y = (w_rem_y >= CNT_Y_W'(MS_PER_S));
    assign w_count = r_s3_cb + CNT_FULL_W'(r_s3_qy) + CNT_FULL_W'(w_fix_y);

    always_comb begin
        o_push        = r_s3_valid;
        o_cmd.op      = r_s3_op;
        o_cmd.shape   = r_s3_shape;
        o_cmd.gmul    = r_s3_gmul;
        o_cmd.step    = PHASE_W'(r_s3_base) + PHASE_W'(r_s3_qx) + PHASE_W'(w_fix_x);
        o_cmd.count   = (64'(w_count) > 64'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(w_count);
        o_cmd.endless = (w_count == '0);
    end

endmodule

// ----- hw/rtl/wtg_queue.sv -----
// Command queue between the front end and the tone engine.
module wtg_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wtg_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output wtg_pkg::t_cmd      o_cmd,
    output wtg_pkg::t_q_status o_status
);
    import wtg_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] r_wr;
    logic [QUEUE_IDX_W-1:0] r_rd;
    logic [QUEUE_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_cmd              = r_mem[r_rd];
    assign o_status.not_empty = (r_cnt != '0);
    assign o_status.full      = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));

endmodule

// ----- hw/rtl/wtg_engine.sv -----
// Tone engine: holds the tone state, builds the waveform and scales the sample.
module wtg_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wtg_pkg::t_cmd      i_cmd,
    input  wtg_pkg::t_q_status i_status,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output wtg_pkg::t_out_beat o_out_beat
);
    import wtg_pkg::*;

    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] r_step;
    logic [COUNT_W-1:0] r_left;
    logic               r_forever;
    logic               r_playing;
    logic [SHAPE_W-1:0] r_shape;
    logic [GMUL_W-1:0]  r_gmul;
    logic [NOISE_W-1:0] r_noise;

    logic [PHASE_W-1:0] n_phase;
    logic [PHASE_W-1:0] n_step;
    logic [COUNT_W-1:0] n_left;
    logic               n_forever;
    logic               n_playing;
    logic [SHAPE_W-1:0] n_shape;
    logic [GMUL_W-1:0]  n_gmul;
    logic [NOISE_W-1:0] n_noise;

    logic                     w_adv;
    logic                     w_tick_on;
    logic                     w_fin;
    logic [NOISE_W-1:0]       w_n1;
    logic [NOISE_W-1:0]       w_n2;
    logic [NOISE_W-1:0]       w_noise_next;
    logic [PHASE_W-1:0]       w_tri_d;
    logic [SINE_ADDR_W-1:0]   w_rom_addr;
    logic [ROM_W-1:0]         w_rom_val;
    logic signed [WAVE_W-1:0] w_sine;
    logic signed [WAVE_W-1:0] w_wave;
    logic [MAG_W-1:0]         w_mag;

    logic                    r_e1_valid;
    logic [MAG_W-1:0]        r_e1_mag;
    logic                    r_e1_neg;
    logic [GMUL_W-1:0]       r_e1_gmul;
    logic                    r_e1_fin;
    logic                    r_e1_act;

    logic                    r_e2_valid;
    logic [SCALE_PROD_W-1:0] r_e2_prod;
    logic                    r_e2_neg;
    logic                    r_e2_fin;
    logic                    r_e2_act;

    logic [SCALE_Q_W-1:0]         w_q;
    logic signed [SAMPLE_W-1:0]   w_sample;
    logic                         r_out_valid;
    t_out_beat                    r_out_beat;

    assign w_adv = !r_out_valid || i_out_ready;
    assign o_pop = w_adv && i_status.not_empty;

    assign w_n1         = r_noise ^ (r_noise << NOISE_SHL_A);
    assign w_n2         = w_n1 ^ (w_n1 >> NOISE_SHR_B);
    assign w_noise_next = w_n2 ^ (w_n2 << NOISE_SHL_C);

    assign w_tri_d = r_phase[PHASE_W-1] ? {1'b0, r_phase[PHASE_W-2:0]}
                                        : (32'h8000_0000 - r_phase);

    assign w_rom_addr = r_phase[PHASE_W-2] ?
        (SINE_ADDR_W'(SINE_TABLE_DEPTH) - {1'b0, r_phase[PHASE_W-3 -: SINE_IDX_W]}) :
        {1'b0, r_phase[PHASE_W-3 -: SINE_IDX_W]};
    assign w_rom_val  = SINE_ROM[w_rom_addr];
    assign w_sine     = signed'({2'b00, w_rom_val});

    always_comb begin
        case (r_shape)
            SHAPE_SQUARE:   w_wave = r_phase[PHASE_W-1] ? -WAVE_FULL : WAVE_FULL;
            SHAPE_TRIANGLE: w_wave = signed'({1'b0, w_tri_d[PHASE_W-1:15]}) - WAVE_FULL;
            SHAPE_SAW:      w_wave = signed'({2'b00, r_phase[PHASE_W-1:16]}) - WAVE_FULL;
            SHAPE_SINE:     w_wave = r_phase[PHASE_W-1] ? -w_sine : w_sine;
            SHAPE_NOISE:    w_wave = WAVE_W'(signed'(w_noise_next[NOISE_W-1:16]));
            default:        w_wave = '0;
        endcase
    end

    assign w_mag = w_wave[WAVE_W-1] ? MAG_W'(-w_wave) : MAG_W'(w_wave);

    always_comb begin
        n_phase   = r_phase;
        n_step    = r_step;
        n_left    = r_left;
        n_forever = r_forever;
        n_playing = r_playing;
        n_shape   = r_shape;
        n_gmul    = r_gmul;
        n_noise   = r_noise;
        w_tick_on = 1'b0;
        w_fin     = 1'b0;
        if (o_pop) begin
            unique case (i_cmd.op)
                OP_TICK: begin
                    if (r_playing) begin
                        w_tick_on = 1'b1;
                        n_phase   = r_phase + r_step;
                        if (r_shape == SHAPE_NOISE) begin
                            n_noise = w_noise_next;
                        end
                        if (!r_forever && (r_left != '0)) begin
                            n_left = r_left - 1'b1;
                            if (r_left == COUNT_W'(1)) begin
                                n_playing = 1'b0;
                                w_fin     = 1'b1;
                            end
                        end
                    end
                end
                OP_START: begin
                    n_step    = i_cmd.step;
                    n_phase   = '0;
                    n_gmul    = i_cmd.gmul;
                    n_shape   = i_cmd.shape;
                    n_left    = i_cmd.count;
                    n_forever = i_cmd.endless;
                    n_playing = 1'b1;
                end
                OP_STOP: begin
                    n_playing = 1'b0;
                end
                default: begin
                    n_playing = r_playing;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_step      <= '0;
            r_left      <= '0;
            r_forever   <= 1'b0;
            r_playing   <= 1'b0;
            r_shape     <= '0;
            r_gmul      <= '0;
            r_noise     <= NOISE_SEED;
            r_e1_valid  <= 1'b0;
            r_e2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_step    <= n_step;
            r_left    <= n_left;
            r_forever <= n_forever;
            r_playing <= n_playing;
            r_shape   <= n_shape;
            r_gmul    <= n_gmul;
            r_noise   <= n_noise;
            if (w_adv) begin
                r_e1_valid  <= o_pop;
                r_e2_valid  <= r_e1_valid;
                r_out_valid <= r_e2_valid;
            end
        end
    end

    assign w_q = r_e2_prod[SCALE_SHIFT +: SCALE_Q_W];

    always_comb begin
        if (r_e2_neg) begin
            w_sample = (w_q >= SCALE_Q_W'(SAMPLE_NEG_LIM)) ? SAMPLE_MIN
                                                          : -signed'(SAMPLE_W'(w_q));
        end else begin
            w_sample = (w_q > SCALE_Q_W'(SAMPLE_POS_LIM)) ? SAMPLE_MAX
                                                         : signed'(SAMPLE_W'(w_q));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e1_mag  <= w_tick_on ? w_mag : '0;
            r_e1_neg  <= w_tick_on && w_wave[WAVE_W-1];
            r_e1_gmul <= r_gmul;
            r_e1_fin  <= w_fin;
            r_e1_act  <= n_playing;

            r_e2_prod <= SCALE_PROD_W'(r_e1_mag) * SCALE_PROD_W'(r_e1_gmul)
                         + SCALE_PROD_W'(SCALE_BIAS);
            r_e2_neg  <= r_e1_neg;
            r_e2_fin  <= r_e1_fin;
            r_e2_act  <= r_e1_act;

            r_out_beat.sample        <= w_sample;
            r_out_beat.tone_finished <= r_e2_fin;
            r_out_beat.tone_active   <= r_e2_act;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule
